### hdl/cnlw_pkg.sv
// Package for the character-LCD nibble writer: request and transfer types,
// command codes, the microcode word format, the control program and its entry table.
// Depends on nothing.
`default_nettype none

package cnlw_pkg;

    localparam int PC_W = 5;

    localparam logic [2:0] CMD_INSTR = 3'd0;
    localparam logic [2:0] CMD_DATA  = 3'd1;
    localparam logic [2:0] CMD_DEC   = 3'd2;
    localparam logic [2:0] CMD_HEX   = 3'd3;
    localparam logic [2:0] CMD_GLYPH = 3'd4;
    localparam logic [2:0] CMD_INIT  = 3'd5;

    localparam logic [PC_W-1:0] PC_INSTR = 5'd0;
    localparam logic [PC_W-1:0] PC_DATA  = 5'd1;
    localparam logic [PC_W-1:0] PC_DEC   = 5'd2;
    localparam logic [PC_W-1:0] PC_DIGIT = 5'd3;
    localparam logic [PC_W-1:0] PC_HEX   = 5'd6;
    localparam logic [PC_W-1:0] PC_GLYPH = 5'd15;
    localparam logic [PC_W-1:0] PC_ROW   = 5'd16;
    localparam logic [PC_W-1:0] PC_INIT  = 5'd17;

    localparam logic [39:0] GLYPH_RESET = 40'd15603149120;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCCCCCD;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  byte_value;
        logic [7:0]  position;
        logic [30:0] number;
        logic [2:0]  glyph_slot;
    } req_t;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last;
    } xfer_t;

    typedef enum logic [3:0] {
        SRC_NONE,
        SRC_BYTE,
        SRC_ADDR,
        SRC_DIGIT,
        SRC_CONST,
        SRC_HEXHI,
        SRC_HEXLO,
        SRC_GADDR,
        SRC_ROW
    } src_t;

    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_LOAD_DEC,
        ADDR_LOAD_POS,
        ADDR_INC,
        ADDR_DEC
    } addr_op_t;

    typedef enum logic [1:0] {
        WORK_HOLD,
        WORK_LOAD,
        WORK_QUOT
    } work_op_t;

    typedef enum logic [1:0] {
        CTR_HOLD,
        CTR_CLR,
        CTR_INC
    } ctr_op_t;

    typedef enum logic [1:0] {
        FIN_NO,
        FIN_YES,
        FIN_DEC,
        FIN_ROW
    } fin_t;

    typedef enum logic [1:0] {
        NXT_SEQ,
        NXT_END,
        NXT_LOOP
    } nxt_t;

    typedef struct packed {
        logic            emit;
        logic            rs;
        src_t            src;
        logic [7:0]      konst;
        addr_op_t        addr_op;
        work_op_t        work_op;
        ctr_op_t         ctr_op;
        fin_t            fin;
        nxt_t            nxt;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        ucode_t word;
        logic   start;
        logic   exec;
        logic   fire_hi;
        logic   fire_lo;
    } ctrl_t;

    typedef struct packed {
        logic final_flag;
        logic slot_free;
    } stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
        begin
            c = 8'h30 + {4'd0, v};
        end
        else
        begin
            c = 8'h37 + {4'd0, v};
        end
        return c;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] cmd);
        logic [PC_W-1:0] pc;
        unique case (cmd)
            CMD_INSTR: pc = PC_INSTR;
            CMD_DATA:  pc = PC_DATA;
            CMD_DEC:   pc = PC_DEC;
            CMD_HEX:   pc = PC_HEX;
            CMD_GLYPH: pc = PC_GLYPH;
            CMD_INIT:  pc = PC_INIT;
            default:   pc = PC_INSTR;
        endcase
        return pc;
    endfunction

    function automatic ucode_t emit_const(input logic rs, input logic [7:0] k);
        ucode_t w;
        w       = '0;
        w.emit  = 1'b1;
        w.rs    = rs;
        w.src   = SRC_CONST;
        w.konst = k;
        return w;
    endfunction

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        unique case (pc)
            5'd0:
            begin
                w.emit = 1'b1;
                w.src  = SRC_BYTE;
                w.fin  = FIN_YES;
                w.nxt  = NXT_END;
            end
            5'd1:
            begin
                w.emit = 1'b1;
                w.rs   = 1'b1;
                w.src  = SRC_BYTE;
                w.fin  = FIN_YES;
                w.nxt  = NXT_END;
            end
            5'd2:
            begin
                w.addr_op = ADDR_LOAD_DEC;
                w.work_op = WORK_LOAD;
                w.ctr_op  = CTR_CLR;
            end
            5'd3:
            begin
                w.src = SRC_NONE;
            end
            5'd4:
            begin
                w.emit = 1'b1;
                w.src  = SRC_ADDR;
            end
            5'd5:
            begin
                w.emit    = 1'b1;
                w.rs      = 1'b1;
                w.src     = SRC_DIGIT;
                w.fin     = FIN_DEC;
                w.addr_op = ADDR_DEC;
                w.work_op = WORK_QUOT;
                w.ctr_op  = CTR_INC;
                w.nxt     = NXT_LOOP;
                w.target  = PC_DIGIT;
            end
            5'd6:
            begin
                w.addr_op = ADDR_LOAD_POS;
            end
            5'd7, 5'd9, 5'd11, 5'd13:
            begin
                w.emit    = 1'b1;
                w.src     = SRC_ADDR;
                w.addr_op = ADDR_INC;
            end
            5'd8:  w = emit_const(1'b1, 8'h30);
            5'd10: w = emit_const(1'b1, 8'h78);
            5'd12:
            begin
                w.emit = 1'b1;
                w.rs   = 1'b1;
                w.src  = SRC_HEXHI;
            end
            5'd14:
            begin
                w.emit = 1'b1;
                w.rs   = 1'b1;
                w.src  = SRC_HEXLO;
                w.fin  = FIN_YES;
                w.nxt  = NXT_END;
            end
            5'd15:
            begin
                w.emit   = 1'b1;
                w.src    = SRC_GADDR;
                w.ctr_op = CTR_CLR;
            end
            5'd16:
            begin
                w.emit   = 1'b1;
                w.rs     = 1'b1;
                w.src    = SRC_ROW;
                w.fin    = FIN_ROW;
                w.ctr_op = CTR_INC;
                w.nxt    = NXT_LOOP;
                w.target = PC_ROW;
            end
            5'd17: w = emit_const(1'b0, 8'h33);
            5'd18: w = emit_const(1'b0, 8'h32);
            5'd19: w = emit_const(1'b0, 8'h28);
            5'd20: w = emit_const(1'b0, 8'h0C);
            5'd21: w = emit_const(1'b0, 8'h01);
            5'd22: w = emit_const(1'b0, 8'h06);
            5'd23:
            begin
                w     = emit_const(1'b0, 8'h80);
                w.fin = FIN_YES;
                w.nxt = NXT_END;
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### hdl/cnlw_sequencer.sv
// Microcode sequencer: step counter, nibble phase, busy flag and jump logic.
// Depends on cnlw_pkg for the control program and the control word format.
`default_nettype none

module cnlw_sequencer
    import cnlw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire logic [2:0] command,
    output logic            cmd_ready,
    input  wire stat_t      stat,
    output ctrl_t           ctrl
);

    logic            busy_reg, busy_next;
    logic            phase_reg, phase_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          word;
    logic            start;
    logic            exec;

    assign word      = ucode_rom(pc_reg);
    assign cmd_ready = !busy_reg;
    assign start     = cmd_valid && !busy_reg;
    assign exec      = busy_reg && (!word.emit || (phase_reg && stat.slot_free));

    assign ctrl.word    = word;
    assign ctrl.start   = start;
    assign ctrl.exec    = exec;
    assign ctrl.fire_hi = busy_reg && word.emit && !phase_reg && stat.slot_free;
    assign ctrl.fire_lo = busy_reg && word.emit && phase_reg && stat.slot_free;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        pc_next    = pc_reg;
        if (start)
        begin
            busy_next  = (command <= CMD_INIT);
            pc_next    = entry_pc(command);
            phase_next = 1'b0;
        end
        else if (exec)
        begin
            phase_next = 1'b0;
            case (word.nxt)
                NXT_END:  busy_next = 1'b0;
                NXT_LOOP:
                begin
                    if (stat.final_flag)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        pc_next = word.target;
                    end
                end
                default:  pc_next = pc_reg + PC_W'(1);
            endcase
        end
        else if (ctrl.fire_hi)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            pc_reg    <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

`default_nettype wire

### hdl/cnlw_datapath.sv
// Datapath: request latch, address and digit registers, divide-by-ten, glyph register,
// byte selection and the transfer output register. Depends on cnlw_pkg.
`default_nettype none

module cnlw_datapath
    import cnlw_pkg::*;
#(
    parameter int MAX_DIGITS = 7
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire req_t        req,
    input  wire logic        cfg_we,
    input  wire logic [39:0] cfg_data,
    input  wire ctrl_t       ctrl,
    output stat_t            stat,
    output logic             xfer_valid,
    input  wire logic        xfer_ready,
    output xfer_t            xfer_data
);

    localparam int CNT_W = (MAX_DIGITS > 8) ? $clog2(MAX_DIGITS) : 3;
    localparam logic [7:0] DIGIT_OFS = 8'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_DIGITS - 1);

    req_t             req_reg;
    logic [39:0]      glyph_reg;
    logic [7:0]       addr_reg, addr_next;
    logic [30:0]      work_reg, work_next;
    logic [62:0]      prod_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg;
    xfer_t            data_reg;

    logic [27:0]      quot;
    logic [30:0]      quot_x10;
    logic [3:0]       rem;
    logic [2:0]       row;
    logic [7:0]       sel_byte;
    logic             final_flag;

    assign quot     = prod_reg[62:35];
    assign quot_x10 = {quot[27:0], 3'b000} + {2'b00, quot[27:0], 1'b0};
    assign rem      = 4'(work_reg - quot_x10);
    assign row      = cnt_reg[2:0];

    always_comb
    begin
        case (ctrl.word.src)
            SRC_BYTE:  sel_byte = req_reg.byte_value;
            SRC_ADDR:  sel_byte = addr_reg;
            SRC_DIGIT: sel_byte = 8'h30 | {4'd0, rem};
            SRC_CONST: sel_byte = ctrl.word.konst;
            SRC_HEXHI: sel_byte = hex_char(req_reg.number[7:4]);
            SRC_HEXLO: sel_byte = hex_char(req_reg.number[3:0]);
            SRC_GADDR: sel_byte = {2'b01, req_reg.glyph_slot, 3'b000};
            SRC_ROW:   sel_byte = {3'b000, glyph_reg[5*row +: 5]};
            default:   sel_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        case (ctrl.word.fin)
            FIN_YES: final_flag = 1'b1;
            FIN_DEC: final_flag = (quot == 28'd0) || (cnt_reg == CNT_LAST);
            FIN_ROW: final_flag = (row == 3'd7);
            default: final_flag = 1'b0;
        endcase
    end

    assign stat.final_flag = final_flag;
    assign stat.slot_free  = !valid_reg || xfer_ready;

    always_comb
    begin
        addr_next = addr_reg;
        work_next = work_reg;
        cnt_next  = cnt_reg;
        if (ctrl.exec)
        begin
            case (ctrl.word.addr_op)
                ADDR_LOAD_DEC: addr_next = req_reg.position + DIGIT_OFS;
                ADDR_LOAD_POS: addr_next = req_reg.position;
                ADDR_INC:      addr_next = addr_reg + 8'd1;
                ADDR_DEC:      addr_next = addr_reg - 8'd1;
                default:       addr_next = addr_reg;
            endcase
            case (ctrl.word.work_op)
                WORK_LOAD: work_next = req_reg.number;
                WORK_QUOT: work_next = {3'b000, quot};
                default:   work_next = work_reg;
            endcase
            case (ctrl.word.ctr_op)
                CTR_CLR: cnt_next = '0;
                CTR_INC: cnt_next = cnt_reg + CNT_W'(1);
                default: cnt_next = cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            req_reg <= req;
        end
        addr_reg <= addr_next;
        work_reg <= work_next;
        cnt_reg  <= cnt_next;
        prod_reg <= {32'd0, work_reg} * {31'd0, RECIP_TEN};
        if (ctrl.fire_hi)
        begin
            data_reg.register_select <= ctrl.word.rs;
            data_reg.nibble          <= sel_byte[7:4];
            data_reg.last            <= 1'b0;
        end
        else if (ctrl.fire_lo)
        begin
            data_reg.register_select <= ctrl.word.rs;
            data_reg.nibble          <= sel_byte[3:0];
            data_reg.last            <= final_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            glyph_reg <= GLYPH_RESET;
        end
        else
        begin
            if (ctrl.fire_hi || ctrl.fire_lo)
            begin
                valid_reg <= 1'b1;
            end
            else if (xfer_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                glyph_reg <= cfg_data;
            end
        end
    end

    assign xfer_valid = valid_reg;
    assign xfer_data  = data_reg;

endmodule

`default_nettype wire

### hdl/char_lcd_nibble_writer_top.sv
// Top level of the character-LCD nibble writer: sequencer plus datapath.
// Depends on cnlw_pkg, cnlw_sequencer and cnlw_datapath.
// One request is worked at a time; hex and decimal requests first load the address, and decimal
// also waits on the registered divide, then up to one transfer a cycle leaves under xfer_ready.
// Reset clears the sequencer and the output valid flag and loads the default glyph.
`default_nettype none

module char_lcd_nibble_writer_top
    import cnlw_pkg::*;
#(
    parameter int MAX_DIGITS = 7
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire req_t        cmd_data,
    output logic             xfer_valid,
    input  wire logic        xfer_ready,
    output xfer_t            xfer_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [39:0] cfg_data
);

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    cnlw_sequencer u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .command   (cmd_data.command),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    cnlw_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (cmd_data),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .ctrl       (ctrl),
        .stat       (stat),
        .xfer_valid (xfer_valid),
        .xfer_ready (xfer_ready),
        .xfer_data  (xfer_data)
    );

endmodule

`default_nettype wire

### tb/char_lcd_nibble_writer_top_tb.sv
// Testbench for char_lcd_nibble_writer_top: drives display requests and glyph writes,
// predicts every nibble transfer and checks each one as it leaves the block.
// Depends on cnlw_pkg and the char_lcd_nibble_writer_top RTL.
`timescale 1ns / 1ps

module char_lcd_nibble_writer_top_tb;
    import cnlw_pkg::*;

    localparam int DIGITS = 7;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 50;

    class nibble_scoreboard;
        xfer_t       due[$];
        logic [39:0] glyph;
        int          errors;

        function new();
            glyph  = GLYPH_RESET;
            errors = 0;
        endfunction

        function void set_glyph(logic [39:0] rows);
            glyph = rows;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function logic [7:0] ascii_hex(logic [3:0] d);
            string digits;
            digits = "0123456789ABCDEF";
            return digits[d];
        endfunction

        function void push_byte(logic rs, logic [7:0] b);
            xfer_t t;
            t.register_select = rs;
            t.last            = 1'b0;
            t.nibble          = b[7:4];
            due.push_back(t);
            t.nibble          = b[3:0];
            due.push_back(t);
        endfunction

        function void note_request(req_t r);
            int unsigned value;
            int          first;
            logic [7:0]  chars [4];
            logic [7:0]  init_bytes [7];
            xfer_t       t;
            first      = due.size();
            init_bytes = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h01, 8'h06, 8'h80};
            case (r.command)
                CMD_INSTR: push_byte(1'b0, r.byte_value);
                CMD_DATA:  push_byte(1'b1, r.byte_value);
                CMD_DEC:
                begin
                    value = r.number;
                    for (int i = 0; i < DIGITS; i++)
                    begin
                        push_byte(1'b0, 8'(r.position + DIGITS - i));
                        push_byte(1'b1, 8'(8'h30 + value % 10));
                        value = value / 10;
                        if (value == 0)
                        begin
                            break;
                        end
                    end
                end
                CMD_HEX:
                begin
                    chars = '{8'h30, 8'h78, ascii_hex(r.number[7:4]), ascii_hex(r.number[3:0])};
                    for (int k = 0; k < 4; k++)
                    begin
                        push_byte(1'b0, 8'(r.position + k));
                        push_byte(1'b1, chars[k]);
                    end
                end
                CMD_GLYPH:
                begin
                    push_byte(1'b0, 8'h40 | {2'b00, r.glyph_slot, 3'b000});
                    for (int i = 0; i < 8; i++)
                    begin
                        push_byte(1'b1, {3'b000, glyph[5*i +: 5]});
                    end
                end
                CMD_INIT:
                begin
                    for (int i = 0; i < 7; i++)
                    begin
                        push_byte(1'b0, init_bytes[i]);
                    end
                end
                default:
                begin
                end
            endcase
            if (due.size() > first)
            begin
                t      = due.pop_back();
                t.last = 1'b1;
                due.push_back(t);
            end
        endfunction

        function void check_xfer(xfer_t got);
            xfer_t want;
            if (due.size() == 0)
            begin
                $error("unexpected transfer: register_select %0d nibble %h last %0d",
                       got.register_select, got.nibble, got.last);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.register_select !== want.register_select)
            begin
                $error("register_select: expected %0d, got %0d",
                       want.register_select, got.register_select);
                errors++;
            end
            if (got.nibble !== want.nibble)
            begin
                $error("nibble: expected %h, got %h", want.nibble, got.nibble);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    req_t        cmd_data = '0;
    logic        xfer_valid;
    logic        xfer_ready = 1'b0;
    xfer_t       xfer_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [39:0] cfg_data = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 30;

    nibble_scoreboard board;

    char_lcd_nibble_writer_top #(
        .MAX_DIGITS(DIGITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_data(cmd_data),
        .xfer_valid(xfer_valid),
        .xfer_ready(xfer_ready),
        .xfer_data(xfer_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        xfer_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && xfer_valid && xfer_ready)
        begin
            board.check_xfer(xfer_data);
        end
    end

    function automatic req_t make_request(logic [2:0] command, logic [7:0] byte_value,
                                          logic [7:0] position, logic [30:0] number,
                                          logic [2:0] glyph_slot);
        req_t r;
        r.command    = command;
        r.byte_value = byte_value;
        r.position   = position;
        r.number     = number;
        r.glyph_slot = glyph_slot;
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        r.byte_value = 8'($urandom);
        r.glyph_slot = 3'($urandom);
        if ($urandom_range(3) == 0)
        begin
            r.position = 8'($urandom_range(8'hFF, 8'hF0));
        end
        else
        begin
            r.position = 8'($urandom);
        end
        case ($urandom_range(3))
            0: r.number = 31'($urandom_range(99));
            1: r.number = 31'($urandom_range(9999999));
            2: r.number = 31'($urandom_range(32'h7FFFFFFF, 10000000));
            default: r.number = 31'($urandom);
        endcase
        if ($urandom_range(99) < 4)
        begin
            r.command = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
        end
        else
        begin
            r.command = 3'($urandom_range(CMD_INIT));
        end
        return r;
    endfunction

    task automatic send_request(req_t r);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= r;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        board.note_request(r);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (board.pending() != 0);
    endtask

    task automatic write_glyph(logic [39:0] rows);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rows;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.set_glyph(rows);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_random(int count, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                drain();
            end
            send_request(random_request());
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(CMD_INSTR, 8'h00, 8'h00, 31'd0, 3'd0));
        send_request(make_request(CMD_INSTR, 8'hFF, 8'hFF, 31'h7FFFFFFF, 3'd7));
        send_request(make_request(CMD_DATA, 8'h00, 8'h00, 31'd0, 3'd0));
        send_request(make_request(CMD_DATA, 8'hFF, 8'hFF, 31'h7FFFFFFF, 3'd7));
        send_request(make_request(CMD_DEC, 8'h00, 8'h80, 31'd0, 3'd0));
        send_request(make_request(CMD_DEC, 8'h00, 8'hF9, 31'd9, 3'd0));
        send_request(make_request(CMD_DEC, 8'h00, 8'hC0, 31'd10, 3'd0));
        send_request(make_request(CMD_DEC, 8'h00, 8'h10, 31'd1234567, 3'd0));
        send_request(make_request(CMD_DEC, 8'h00, 8'hFF, 31'd9999999, 3'd0));
        send_request(make_request(CMD_DEC, 8'h00, 8'h80, 31'd10000000, 3'd0));
        send_request(make_request(CMD_DEC, 8'hFF, 8'h00, 31'h7FFFFFFF, 3'd7));
        send_request(make_request(CMD_HEX, 8'h00, 8'h80, 31'd0, 3'd0));
        send_request(make_request(CMD_HEX, 8'h00, 8'hFE, 31'h7FFFFFFF, 3'd0));
        send_request(make_request(CMD_HEX, 8'h00, 8'h40, 31'h000000A5, 3'd0));
        send_request(make_request(CMD_GLYPH, 8'h00, 8'h00, 31'd0, 3'd0));
        send_request(make_request(CMD_GLYPH, 8'hFF, 8'hFF, 31'h7FFFFFFF, 3'd7));
        send_request(make_request(CMD_INIT, 8'h00, 8'h00, 31'd0, 3'd0));
        send_request(make_request(CMD_SPARE_6, 8'h00, 8'h00, 31'd0, 3'd0));
        send_request(make_request(CMD_SPARE_7, 8'hFF, 8'hFF, 31'h7FFFFFFF, 3'd7));
        send_request(make_request(CMD_INIT, 8'hFF, 8'hFF, 31'h7FFFFFFF, 3'd7));

        write_glyph(40'hFF_FFFF_FFFF);
        send_request(make_request(CMD_GLYPH, 8'h00, 8'h00, 31'd0, 3'd3));
        write_glyph(40'h00_0000_0000);
        send_request(make_request(CMD_GLYPH, 8'h00, 8'h00, 31'd0, 3'd5));

        write_glyph(40'({$urandom, $urandom}));
        run_random(117, 14, 57);
        write_glyph(40'({$urandom, $urandom}));
        run_random(117, 57, 14);
        write_glyph(40'({$urandom, $urandom}));
        run_random(117, 0, 0);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/cnlw_pkg.sv
hdl/cnlw_sequencer.sv
hdl/cnlw_datapath.sv
hdl/char_lcd_nibble_writer_top.sv
tb/char_lcd_nibble_writer_top_tb.sv
